### rtl/core/bdm_pkg.sv
`default_nettype none

package bdm_pkg;

  localparam int PIX_W     = 8;
  localparam int POS_W     = 12;
  localparam int ADDR_W    = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 8;
  localparam int LINE_W    = 2 * PIX_W;
  localparam int OUT_W     = 2 * POS_W + 3 * PIX_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [CFG_W-1:0] DIM_MIN      = 13'd4;
  localparam logic [CFG_W-1:0] DIM_MAX      = 13'd4096;

  // one interpolated pixel together with the edge copies it stands for
  typedef struct packed {
    logic [POS_W-1:0] row_base;
    logic [POS_W-1:0] col_base;
    logic             two_rows;
    logic             two_cols;
    logic             frame_end;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } bdm_px_t;

  // clamp a frame dimension to [4, 4096] and return its last index
  function automatic logic [POS_W-1:0] dim_last(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] m;
    begin
      m = v;
      if (v < DIM_MIN) m = DIM_MIN;
      if (v > DIM_MAX) m = DIM_MAX;
      m = m - 13'd1;
      return m[POS_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/core/bdm_line_mem.sv
`default_nettype none

module bdm_line_mem (
  input  wire logic                      clk,
  input  wire logic                      rd_en,
  input  wire logic [bdm_pkg::ADDR_W-1:0] rd_addr,
  output logic      [bdm_pkg::LINE_W-1:0] rd_data,
  input  wire logic                      wr_en,
  input  wire logic [bdm_pkg::ADDR_W-1:0] wr_addr,
  input  wire logic [bdm_pkg::LINE_W-1:0] wr_data
);
  import bdm_pkg::*;

  localparam int DEPTH = 1 << ADDR_W;

  // each entry: older line sample in the upper half, newer in the lower
  logic [LINE_W-1:0] mem_r [DEPTH];
  logic [LINE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/bdm_interp.sv
`default_nettype none

module bdm_interp (
  input  wire logic                     clk,
  input  wire logic                     shift,
  input  wire logic [bdm_pkg::PIX_W-1:0] older,
  input  wire logic [bdm_pkg::PIX_W-1:0] newer,
  input  wire logic [bdm_pkg::PIX_W-1:0] sample,
  input  wire logic [bdm_pkg::POS_W-1:0] row,
  input  wire logic [bdm_pkg::POS_W-1:0] col,
  input  wire logic [bdm_pkg::POS_W-1:0] width_last,
  input  wire logic [bdm_pkg::POS_W-1:0] height_last,
  output bdm_pkg::bdm_px_t              px
);
  import bdm_pkg::*;

  // two older window columns; the third is the column arriving now
  logic [PIX_W-1:0] win_r [3][2];
  logic [PIX_W-1:0] new_col [3];

  logic [PIX_W+1:0] cross_sum, diag_sum;
  logic [PIX_W:0]   horiz_sum, vert_sum;
  logic [PIX_W-1:0] cross_avg, diag, horiz, vert, center;
  logic             odd_row, odd_col;
  logic             first_row, first_col;

  assign new_col[0] = older;
  assign new_col[1] = newer;
  assign new_col[2] = sample;

  always_ff @(posedge clk) begin
    if (shift) begin
      for (int i = 0; i < 3; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= new_col[i];
      end
    end
  end

  always_comb begin
    cross_sum = {2'b00, win_r[0][1]} + {2'b00, win_r[2][1]} + {2'b00, win_r[1][0]}
              + {2'b00, new_col[1]} + 10'd2;
    diag_sum  = {2'b00, win_r[0][0]} + {2'b00, new_col[0]} + {2'b00, win_r[2][0]}
              + {2'b00, new_col[2]} + 10'd2;
    horiz_sum = {1'b0, win_r[1][0]} + {1'b0, new_col[1]} + 9'd1;
    vert_sum  = {1'b0, win_r[0][1]} + {1'b0, win_r[2][1]} + 9'd1;
    cross_avg = cross_sum[PIX_W+1:2];
    diag      = diag_sum[PIX_W+1:2];
    horiz     = horiz_sum[PIX_W:1];
    vert      = vert_sum[PIX_W:1];
    center    = win_r[1][1];
  end

  // the completed pixel sits one row up and one column left
  assign odd_row   = ~row[0];
  assign odd_col   = ~col[0];
  assign first_row = (row == 12'd2);
  assign first_col = (col == 12'd2);

  always_comb begin
    px.row_base  = first_row ? '0 : row - 12'd1;
    px.col_base  = first_col ? '0 : col - 12'd1;
    px.two_rows  = first_row || (row == height_last);
    px.two_cols  = first_col || (col == width_last);
    px.frame_end = (row == height_last) && (col == width_last);
    case ({odd_row, odd_col})
      2'b00: begin
        px.blue = diag;   px.green = cross_avg; px.red = center;
      end
      2'b11: begin
        px.blue = center; px.green = cross_avg; px.red = diag;
      end
      2'b01: begin
        px.blue = vert;   px.green = center;    px.red = horiz;
      end
      default: begin
        px.blue = horiz;  px.green = center;    px.red = vert;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/bdm_emit.sv
`default_nettype none

module bdm_emit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     load,
  input  wire bdm_pkg::bdm_px_t         px,
  output logic                          free,
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic [bdm_pkg::OUT_W-1:0]     out_tdata,  // row, column, blue, green, red
  output logic                          out_tlast,
  output logic                          out_tuser   // frame_done
);
  import bdm_pkg::*;

  bdm_px_t          px_r;
  logic             valid_r;
  logic             row_sel_r, col_sel_r;
  logic             last;
  logic [POS_W-1:0] out_row, out_col;

  assign last = (row_sel_r == px_r.two_rows) && (col_sel_r == px_r.two_cols);
  assign free = !valid_r || (out_tready && last);

  // walks the copies left to right, top row first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      row_sel_r <= 1'b0;
      col_sel_r <= 1'b0;
    end else if (load) begin
      valid_r   <= 1'b1;
      row_sel_r <= 1'b0;
      col_sel_r <= 1'b0;
    end else if (valid_r && out_tready) begin
      if (last) begin
        valid_r <= 1'b0;
      end else if (col_sel_r != px_r.two_cols) begin
        col_sel_r <= 1'b1;
      end else begin
        col_sel_r <= 1'b0;
        row_sel_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r <= px;
    end
  end

  assign out_row    = px_r.row_base + {{(POS_W-1){1'b0}}, row_sel_r};
  assign out_col    = px_r.col_base + {{(POS_W-1){1'b0}}, col_sel_r};
  assign out_tvalid = valid_r;
  assign out_tdata  = {px_r.red, px_r.green, px_r.blue, out_col, out_row};
  assign out_tlast  = last;
  assign out_tuser  = last && px_r.frame_end;

endmodule

`default_nettype wire

### rtl/core/bayer_rggb_bilinear_demosaic_top.sv
`default_nettype none

// Bilinear demosaic of an RGGB Bayer stream (red at even row and column). Samples enter in
// raster order on in_tdata; each interior pixel leaves as row, column and blue/green/red,
// with the frame border filled by copies of the nearest interior pixel. A pixel is complete
// one row and one column after its sample, and reaches out_tdata through stage one and the
// output register. The block takes one sample per cycle while each sample completes at
// most one pixel and out_tready is high; a sample that completes a border pixel emits two
// or four results (first/last interior row or column) and holds the input meanwhile, as
// the single output register hands out one result per ready cycle. The two previous rows
// live in one 4096 x 16 line memory read at the sample's column and written back as stage
// one advances. Writing frame_width (index 0) or frame_height (index 1) restarts the
// frame; other indexes are ignored. Dimensions are clamped to 4..4096.
module bayer_rggb_bilinear_demosaic_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [bdm_pkg::PIX_W-1:0]    in_tdata,   // raw_sample
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [bdm_pkg::OUT_W-1:0]         out_tdata,  // out_row, out_column, blue, green, red
  output logic                              out_tlast,  // last_of_run
  output logic                              out_tuser,  // frame_done
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [bdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bdm_pkg::CFG_W-1:0]    cfg_data
);
  import bdm_pkg::*;

  logic [POS_W-1:0]  width_last_r, height_last_r;
  logic [POS_W-1:0]  col_cnt_r, row_cnt_r;
  logic [POS_W-1:0]  col_cnt_nxt, row_cnt_nxt;
  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_sample_r;
  logic [POS_W-1:0]  s1_row_r, s1_col_r;
  logic              s1_emit, s1_advance;
  logic              in_xfer, cfg_xfer, cfg_hit;
  logic              emit_free;
  logic [LINE_W-1:0] line_rd;
  bdm_px_t           px;

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_xfer &&
                     (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
  assign in_xfer   = in_tvalid && in_tready;

  assign s1_emit    = (s1_row_r >= 12'd2) && (s1_col_r >= 12'd2);
  assign s1_advance = s1_valid_r && (!s1_emit || emit_free);
  assign in_tready  = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_last_r  <= dim_last(WIDTH_RESET);
      height_last_r <= dim_last(HEIGHT_RESET);
    end else if (cfg_xfer) begin
      if (cfg_index == REG_FRAME_WIDTH) width_last_r <= dim_last(cfg_data);
      if (cfg_index == REG_FRAME_HEIGHT) height_last_r <= dim_last(cfg_data);
    end
  end

  always_comb begin
    col_cnt_nxt = col_cnt_r + 12'd1;
    row_cnt_nxt = row_cnt_r;
    if (col_cnt_r == width_last_r) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_cnt_r == height_last_r) ? '0 : row_cnt_r + 12'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_hit) begin
        col_cnt_r <= '0;
        row_cnt_r <= '0;
      end else if (in_xfer) begin
        col_cnt_r <= col_cnt_nxt;
        row_cnt_r <= row_cnt_nxt;
      end
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_sample_r <= in_tdata;
      s1_row_r    <= row_cnt_r;
      s1_col_r    <= col_cnt_r;
    end
  end

  // read at acceptance, write back {newer, sample} as the item leaves stage one
  bdm_line_mem u_line_mem (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (col_cnt_r),
    .rd_data (line_rd),
    .wr_en   (s1_advance),
    .wr_addr (s1_col_r),
    .wr_data ({line_rd[PIX_W-1:0], s1_sample_r})
  );

  bdm_interp u_interp (
    .clk         (clk),
    .shift       (s1_advance),
    .older       (line_rd[LINE_W-1:PIX_W]),
    .newer       (line_rd[PIX_W-1:0]),
    .sample      (s1_sample_r),
    .row         (s1_row_r),
    .col         (s1_col_r),
    .width_last  (width_last_r),
    .height_last (height_last_r),
    .px          (px)
  );

  bdm_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_advance && s1_emit),
    .px         (px),
    .free       (emit_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  a_frame_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame_done without last_of_run");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_advance |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_sample_r))
    else $error("stalled sample lost in stage one");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> col_cnt_r == '0 && row_cnt_r == '0)
    else $error("register write did not restart the frame");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_valid_r)
    else $error("accepted sample not in stage one");

endmodule

`default_nettype wire

### dv/bayer_rggb_bilinear_demosaic_top_test.sv
module bayer_rggb_bilinear_demosaic_top_test;

  localparam int MAX_COLS       = 4096;
  localparam int CYCLE_LIMIT    = 600000;
  localparam int DRAIN_SLACK    = 8;
  localparam int RANDOM_SAMPLES = 140;
  localparam int MAX_REPORTS    = 10;
  localparam int STALL_CYCLES   = 300;

  // result tdata layout, lowest bit first
  localparam int ROW_LSB   = 0;
  localparam int COL_LSB   = bdm_pkg::POS_W;
  localparam int BLUE_LSB  = 2 * bdm_pkg::POS_W;
  localparam int GREEN_LSB = BLUE_LSB + bdm_pkg::PIX_W;
  localparam int RED_LSB   = GREEN_LSB + bdm_pkg::PIX_W;

  // indexes with no register behind them
  localparam logic [bdm_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [bdm_pkg::CFG_IDX_W-1:0] REG_TOP   = 8'hFF;

  typedef struct packed {
    logic [bdm_pkg::POS_W-1:0] row;
    logic [bdm_pkg::POS_W-1:0] col;
    logic [bdm_pkg::PIX_W-1:0] blue;
    logic [bdm_pkg::PIX_W-1:0] green;
    logic [bdm_pkg::PIX_W-1:0] red;
    logic                      run_end;
    logic                      frame_end;
  } rgb_pixel_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  logic [bdm_pkg::PIX_W-1:0]     in_tdata;   // raw_sample
  logic                          out_tvalid;
  logic                          out_tready;
  logic [bdm_pkg::OUT_W-1:0]     out_tdata;  // out_row, out_column, blue, green, red
  logic                          out_tlast;  // last_of_run
  logic                          out_tuser;  // frame_done
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [bdm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bdm_pkg::CFG_W-1:0]     cfg_data;

  bayer_rggb_bilinear_demosaic_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predictor state
  logic [bdm_pkg::PIX_W-1:0] older_line [MAX_COLS];
  logic [bdm_pkg::PIX_W-1:0] newer_line [MAX_COLS];
  logic [bdm_pkg::PIX_W-1:0] win [3][3];
  logic [bdm_pkg::CFG_W-1:0] width_reg;
  logic [bdm_pkg::CFG_W-1:0] height_reg;
  int                        col_pos;
  int                        row_pos;

  rgb_pixel_t pending_pixels [$];

  int  cycle_count;
  int  mismatch_count;
  int  samples_sent;
  int  pixels_checked;
  int  frame_setups;
  int  sink_hold_cycles;
  bit  src_idle_on;
  bit  sink_idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               pending_pixels.size());
      $display("bayer_rggb_bilinear_demosaic_top_test NOT OK");
      $finish;
    end
  end

  function automatic int clamp_dim(input logic [bdm_pkg::CFG_W-1:0] v);
    if (v < 13'd4) return 4;
    if (v > 13'd4096) return 4096;
    return int'(v);
  endfunction

  // one raw sample in raster order; queues every color pixel it completes
  task automatic demosaic_step(input logic [bdm_pkg::PIX_W-1:0] s);
    int w, h, ci, cr, cc, nr, nc, n, k, i, a, b;
    int cross_avg, diag_avg, horiz_avg, vert_avg;
    int rows [2];
    int cols [2];
    logic [bdm_pkg::PIX_W-1:0] blue, green, red;
    rgb_pixel_t px;
    w = clamp_dim(width_reg);
    h = clamp_dim(height_reg);
    ci = col_pos % MAX_COLS;
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = older_line[ci];
    win[1][2] = newer_line[ci];
    win[2][2] = s;
    older_line[ci] = newer_line[ci];
    newer_line[ci] = s;

    if (row_pos >= 2 && col_pos >= 2 && row_pos - 1 <= h - 2 && col_pos - 1 <= w - 2) begin
      cr = row_pos - 1;
      cc = col_pos - 1;
      cross_avg = (int'(win[0][1]) + int'(win[2][1]) + int'(win[1][0]) + int'(win[1][2]) + 2)
                  >> 2;
      diag_avg  = (int'(win[0][0]) + int'(win[0][2]) + int'(win[2][0]) + int'(win[2][2]) + 2)
                  >> 2;
      horiz_avg = (int'(win[1][0]) + int'(win[1][2]) + 1) >> 1;
      vert_avg  = (int'(win[0][1]) + int'(win[2][1]) + 1) >> 1;
      case ({cr[0], cc[0]})
        2'b00: begin
          blue = diag_avg[7:0];  green = cross_avg[7:0]; red = win[1][1];
        end
        2'b11: begin
          blue = win[1][1];      green = cross_avg[7:0]; red = diag_avg[7:0];
        end
        2'b01: begin
          blue = vert_avg[7:0];  green = win[1][1];      red = horiz_avg[7:0];
        end
        default: begin
          blue = horiz_avg[7:0]; green = win[1][1];      red = vert_avg[7:0];
        end
      endcase

      // border rows and columns repeat their inner neighbor
      nr = 0;
      if (cr == 1) begin
        rows[nr] = 0;
        nr++;
      end
      rows[nr] = cr;
      nr++;
      if (cr == h - 2 && nr < 2) begin
        rows[nr] = h - 1;
        nr++;
      end
      nc = 0;
      if (cc == 1) begin
        cols[nc] = 0;
        nc++;
      end
      cols[nc] = cc;
      nc++;
      if (cc == w - 2 && nc < 2) begin
        cols[nc] = w - 1;
        nc++;
      end

      n = nr * nc;
      k = 0;
      for (a = 0; a < nr; a++) begin
        for (b = 0; b < nc; b++) begin
          px.row       = 12'(rows[a]);
          px.col       = 12'(cols[b]);
          px.blue      = blue;
          px.green     = green;
          px.red       = red;
          px.run_end   = (k == n - 1);
          px.frame_end = (k == n - 1) && cr == h - 2 && cc == w - 2;
          pending_pixels.push_back(px);
          k++;
        end
      end
    end

    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  task automatic flag_pixel(input string why, input rgb_pixel_t want, input rgb_pixel_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%s: expected row %0d col %0d bgr %0d/%0d/%0d last %b done %b",
               why, want.row, want.col, want.blue, want.green, want.red, want.run_end,
               want.frame_end);
      $display("  got row %0d col %0d bgr %0d/%0d/%0d last %b done %b",
               got.row, got.col, got.blue, got.green, got.red, got.run_end, got.frame_end);
    end
  endtask

  task automatic check_pixel();
    rgb_pixel_t got, want;
    got.row       = out_tdata[ROW_LSB +: bdm_pkg::POS_W];
    got.col       = out_tdata[COL_LSB +: bdm_pkg::POS_W];
    got.blue      = out_tdata[BLUE_LSB +: bdm_pkg::PIX_W];
    got.green     = out_tdata[GREEN_LSB +: bdm_pkg::PIX_W];
    got.red       = out_tdata[RED_LSB +: bdm_pkg::PIX_W];
    got.run_end   = out_tlast;
    got.frame_end = out_tuser;
    if (pending_pixels.size() == 0) begin
      flag_pixel("result with nothing expected", '0, got);
      return;
    end
    want = pending_pixels.pop_front();
    if (got.row !== want.row || got.col !== want.col || got.blue !== want.blue ||
        got.green !== want.green || got.red !== want.red ||
        got.run_end !== want.run_end || got.frame_end !== want.frame_end)
      flag_pixel($sformatf("pixel %0d differs", pixels_checked), want, got);
    pixels_checked++;
  endtask

  // result side: check each transfer, then pick the next ready
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_pixel();
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles = sink_hold_cycles - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(sink_idle_on && $urandom_range(99) < 18);
      end
    end
  end

  task automatic send_sample(input logic [bdm_pkg::PIX_W-1:0] s);
    while (src_idle_on && $urandom_range(99) < 18) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    demosaic_step(s);
    samples_sent++;
  endtask

  task automatic send_random(input int count);
    repeat (count) send_sample(8'($urandom_range(255)));
  endtask

  // wait for every queued pixel, then let a trailing sample settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bdm_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdm_pkg::CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == bdm_pkg::REG_FRAME_WIDTH) begin
      width_reg = value;
      col_pos = 0;
      row_pos = 0;
    end else if (idx == bdm_pkg::REG_FRAME_HEIGHT) begin
      height_reg = value;
      col_pos = 0;
      row_pos = 0;
    end
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [bdm_pkg::CFG_W-1:0] w,
                           input logic [bdm_pkg::CFG_W-1:0] h);
    drain_results();
    if ($urandom_range(1) == 0) begin
      write_reg(bdm_pkg::REG_FRAME_WIDTH, w);
      write_reg(bdm_pkg::REG_FRAME_HEIGHT, h);
    end else begin
      write_reg(bdm_pkg::REG_FRAME_HEIGHT, h);
      write_reg(bdm_pkg::REG_FRAME_WIDTH, w);
    end
    frame_setups++;
  endtask

  // reset size 640x480: the start of the top row completes nothing
  task automatic test_reset_size();
    send_random(24);
  endtask

  // smallest frame from below-minimum values, extreme sample values
  task automatic test_small_extremes();
    logic [bdm_pkg::PIX_W-1:0] pattern [16];
    int i;
    pattern = '{8'd255, 8'd0, 8'd254, 8'd1, 8'd0, 8'd255, 8'd3, 8'd128,
                8'd255, 8'd2, 8'd0, 8'd255, 8'd7, 8'd255, 8'd1, 8'd0};
    set_frame(13'd0, 13'd1);
    for (i = 0; i < 16; i++) send_sample(pattern[i]);
  endtask

  task automatic test_register_writes();
    set_frame(13'd4, 13'd4);
    send_random(6);
    drain_results();
    // unknown indexes must not restart the frame
    write_reg(REG_SPARE, 13'h1FFF);
    write_reg(REG_TOP, 13'd0);
    send_random(10);
    send_random(7);
    drain_results();
    write_reg(bdm_pkg::REG_FRAME_WIDTH, 13'd6);
    send_random(24);
    // largest exact width, a few samples that complete nothing
    set_frame(13'd4096, 13'd4095);
    send_random(9);
  endtask

  task automatic test_output_stall();
    set_frame(13'd8, 13'd6);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    sink_hold_cycles = STALL_CYCLES;
    send_random(48);
    // next frame with a full pause in the middle
    send_random(26);
    drain_results();
    send_random(22);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  task automatic test_random_frames();
    int sent, n, reps;
    logic [bdm_pkg::CFG_W-1:0] w_val, h_val;
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      w_val = ($urandom_range(7) == 0) ? 13'($urandom_range(3)) : 13'($urandom_range(4, 12));
      h_val = ($urandom_range(7) == 0) ? 13'($urandom_range(3)) : 13'($urandom_range(4, 9));
      // one stretch with no idling on either side
      src_idle_on  = !(sent >= 40 && sent < 100);
      sink_idle_on = src_idle_on;
      set_frame(w_val, h_val);
      n = clamp_dim(w_val) * clamp_dim(h_val);
      reps = $urandom_range(1, 2);
      if ($urandom_range(5) == 0) begin
        n = $urandom_range(1, n - 1);
        reps = 1;
      end
      send_random(n * reps);
      sent += n * reps;
    end
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // oversized width clamps to the line length; the top row completes nothing
  task automatic test_widest();
    set_frame(13'h1FFF, 13'd4);
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    send_random(12);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // oversized height: first rows of a narrow frame
  task automatic test_tallest();
    set_frame(13'd4, 13'h1FFF);
    send_random(4 * 6);
  endtask

  initial begin
    int i;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    cycle_count = 0;
    mismatch_count = 0;
    samples_sent = 0;
    pixels_checked = 0;
    frame_setups = 0;
    sink_hold_cycles = 0;
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    width_reg = bdm_pkg::WIDTH_RESET;
    height_reg = bdm_pkg::HEIGHT_RESET;
    col_pos = 0;
    row_pos = 0;
    for (i = 0; i < MAX_COLS; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    win = '{default: '0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_small_extremes();
    test_register_writes();
    test_output_stall();
    test_random_frames();
    test_widest();
    test_tallest();

    drain_results();
    $display("sent %0d raw samples, checked %0d color pixels over %0d frame setups",
             samples_sent, pixels_checked, frame_setups);
    $display("small and odd frames, clamped and oversized settings, restarts, output stalls");
    if (mismatch_count == 0 && pending_pixels.size() == 0) begin
      $display("bayer_rggb_bilinear_demosaic_top_test OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("bayer_rggb_bilinear_demosaic_top_test NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/bdm_pkg.sv
rtl/core/bdm_line_mem.sv
rtl/core/bdm_interp.sv
rtl/core/bdm_emit.sv
rtl/core/bayer_rggb_bilinear_demosaic_top.sv
dv/bayer_rggb_bilinear_demosaic_top_test.sv
